[design/iyfp_pkg.sv]
// Package for the IMU yaw frame parser.
// Frame constants, shared status type and heading conversion. No dependencies.
package iyfp_pkg;

   localparam int RxWidth      = 8;
   localparam int YawWidth     = 16;
   localparam int HeadingWidth = 17;
   localparam int PosWidth     = 4;

   localparam logic [RxWidth-1:0]  FrameHead0   = 8'hAA;
   localparam logic [RxWidth-1:0]  FrameHead1   = 8'h00;
   localparam logic [PosWidth-1:0] PosHead0     = 4'd0;
   localparam logic [PosWidth-1:0] PosHead1     = 4'd1;
   localparam logic [PosWidth-1:0] PosSumStart  = 4'd2;
   localparam logic [PosWidth-1:0] PosYawLow    = 4'd3;
   localparam logic [PosWidth-1:0] PosYawHigh   = 4'd4;
   localparam logic [PosWidth-1:0] PosCheck     = 4'd14;
   localparam logic signed [HeadingWidth-1:0] HeadingOffset = 17'sd18000;

   typedef struct packed {
      logic                       at_check;
      logic                       hit;
      logic signed [YawWidth-1:0] yaw;
   } frame_status_type;

   function automatic logic signed [HeadingWidth-1:0] yaw_to_heading(
      input logic signed [YawWidth-1:0] yaw
   );
      logic signed [HeadingWidth-1:0] yaw_ext;
      yaw_ext = HeadingWidth'(yaw);
      return yaw_ext + HeadingOffset;
   endfunction

endpackage

[design/iyfp_frame_tracker.sv]
// Frame position, running checksum and yaw capture for the IMU yaw frame parser.
// Depends on iyfp_pkg.
module iyfp_frame_tracker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [iyfp_pkg::RxWidth-1:0]     rx_data,
   output iyfp_pkg::frame_status_type       status
);
   import iyfp_pkg::*;

   logic [PosWidth-1:0] pos_ff, pos_in;
   logic [RxWidth-1:0]  sum_ff, sum_in;
   logic [RxWidth-1:0]  yaw_lo_ff, yaw_lo_in;
   logic [RxWidth-1:0]  yaw_hi_ff, yaw_hi_in;
   logic                at_check;

   assign at_check = (pos_ff >= PosCheck);

   always_comb begin
      pos_in    = pos_ff;
      sum_in    = sum_ff;
      yaw_lo_in = yaw_lo_ff;
      yaw_hi_in = yaw_hi_ff;
      if (accept) begin
         priority if (pos_ff == PosHead0) begin
            pos_in = (rx_data == FrameHead0) ? PosHead1 : PosHead0;
         end else if (pos_ff == PosHead1) begin
            pos_in = (rx_data == FrameHead1) ? PosSumStart : PosHead0;
         end else if (!at_check) begin
            sum_in = (pos_ff == PosSumStart) ? rx_data : sum_ff + rx_data;
            if (pos_ff == PosYawLow) yaw_lo_in = rx_data;
            if (pos_ff == PosYawHigh) yaw_hi_in = rx_data;
            pos_in = pos_ff + PosWidth'(1);
         end else begin
            pos_in = PosHead0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         sum_ff    <= '0;
         yaw_lo_ff <= '0;
         yaw_hi_ff <= '0;
      end else begin
         pos_ff    <= pos_in;
         sum_ff    <= sum_in;
         yaw_lo_ff <= yaw_lo_in;
         yaw_hi_ff <= yaw_hi_in;
      end
   end

   assign status.at_check = at_check;
   assign status.hit      = accept && at_check && (sum_ff == rx_data);
   assign status.yaw      = {yaw_hi_ff, yaw_lo_ff};

endmodule

[design/imu_yaw_frame_parser_unit.sv]
// Top level of the IMU yaw frame parser: byte input, frame tracker, result register.
// Depends on iyfp_pkg and iyfp_frame_tracker.
//
//   channel | ports                                   | direction
//   req     | req_valid, req_stall, req_rx_data       | byte in
//   rsp     | rsp_valid, rsp_stall, rsp_heading_centideg, rsp_raw_yaw | yaw result out
//
// One byte per cycle while req_stall is low; a good checksum byte gives a result in the next cycle.
// Reset clears the frame position, checksum and result valid.
// req_stall rises only when the next byte is a checksum byte and a result
// still waits in the output register; all other bytes are taken regardless.
module imu_yaw_frame_parser_unit (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [iyfp_pkg::RxWidth-1:0]              req_rx_data,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic signed [iyfp_pkg::HeadingWidth-1:0]  rsp_heading_centideg,
   output logic signed [iyfp_pkg::YawWidth-1:0]      rsp_raw_yaw
);
   import iyfp_pkg::*;

   frame_status_type               status;
   logic                           accept;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [HeadingWidth-1:0] heading_ff, heading_in;
   logic signed [YawWidth-1:0]     yaw_ff, yaw_in;

   assign req_stall = status.at_check && rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   iyfp_frame_tracker u_tracker (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_data (req_rx_data),
      .status  (status)
   );

   always_comb begin
      rsp_valid_in = status.hit || (rsp_valid_ff && rsp_stall);
      heading_in   = heading_ff;
      yaw_in       = yaw_ff;
      if (status.hit) begin
         heading_in = yaw_to_heading(status.yaw);
         yaw_in     = status.yaw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      heading_ff <= heading_in;
      yaw_ff     <= yaw_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_heading_centideg = heading_ff;
   assign rsp_raw_yaw          = yaw_ff;

   // no result may overwrite one still held
   assert property (@(posedge clock) disable iff (reset)
      !(status.hit && rsp_valid_ff && rsp_stall))
      else $error("result overwritten while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_heading_centideg == yaw_to_heading(rsp_raw_yaw)))
      else $error("heading does not match yaw");

   assert property (@(posedge clock) disable iff (reset)
      status.hit |=> rsp_valid_ff && (rsp_raw_yaw == $past(status.yaw)))
      else $error("frame hit not registered");

endmodule
